// ===== rtl/core/tlim_pkg.sv =====
package tlim_pkg;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OUT      = 3'd1;
  localparam logic [2:0] ST_HALT     = 3'd2;
  localparam logic [2:0] ST_STRAY    = 3'd3;
  localparam logic [2:0] ST_UNCLOSED = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  // input commands
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_EXEC   = 1'b1;

  // instruction characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  // one word between the front and the back
  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } tlim_word_t;

endpackage

// ===== rtl/core/tlim_front.sv =====
module tlim_front
  import tlim_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_data_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output tlim_word_t q_word
);

  // two-entry queue
  tlim_word_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_word   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // pointer and count update
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{command: in_command, data_byte: in_data_byte};
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule

// ===== rtl/core/tlim_back.sv =====
module tlim_back
  import tlim_pkg::*;
#(
  parameter int TAPE_CELLS    = 1024,
  parameter int PROGRAM_DEPTH = 1024,
  parameter int STACK_DEPTH   = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  tlim_word_t q_word,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_out_byte,
  output logic [10:0] out_program_counter
);

  localparam int TW = (TAPE_CELLS > 1) ? $clog2(TAPE_CELLS) : 1;
  localparam int PW = $clog2(PROGRAM_DEPTH);
  localparam int LW = PW + 1;
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH) + 1;
  localparam logic [TW-1:0] TAPE_LAST = TW'(TAPE_CELLS - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_SCANR = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [7:0]    prog_mem [PROGRAM_DEPTH];
  logic [7:0]    tape_mem [TAPE_CELLS];
  logic [PW-1:0] stk_mem  [STACK_DEPTH];
  logic [7:0]    op_r, cell_r;
  logic [PW-1:0] top_r;

  // architectural state
  logic [LW-1:0] len_r, len_nxt;
  logic [TW-1:0] ptr_r, ptr_nxt;
  logic [LW-1:0] ip_r, ip_nxt;
  logic [DW-1:0] dep_r, dep_nxt;
  logic          halt_r, halt_nxt;
  logic [TW-1:0] clr_r, clr_nxt;
  tlim_word_t    w_r, w_nxt;
  logic [LW-1:0] scan_r, scan_nxt;
  logic [DW+PW:0] lvl_r, lvl_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [7:0]    ob_r, ob_nxt;

  // memory control
  logic          pw_en, tw_en, sw_en;
  logic [PW-1:0] pr_addr;
  logic [7:0]    tw_data;
  logic [TW-1:0] tw_addr;

  assign q_ready             = (state_r == S_IDLE);
  assign out_valid           = (state_r == S_OUT);
  assign out_status          = st_r;
  assign out_out_byte        = ob_r;
  assign out_program_counter = 11'(ip_r);

  always_comb begin
    state_nxt = state_r;
    len_nxt = len_r; ptr_nxt = ptr_r; ip_nxt = ip_r; dep_nxt = dep_r;
    halt_nxt = halt_r; clr_nxt = clr_r; w_nxt = w_r;
    scan_nxt = scan_r; lvl_nxt = lvl_r; st_nxt = st_r; ob_nxt = ob_r;
    pw_en = 1'b0; tw_en = 1'b0; sw_en = 1'b0;
    pr_addr = ip_r[PW-1:0];
    tw_addr = ptr_r;
    tw_data = 8'd0;
    case (state_r)
      // clearing pass over the tape
      S_CLEAR: begin
        tw_en   = 1'b1;
        tw_addr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TAPE_LAST) state_nxt = S_IDLE;
      end
      // take a word and classify it
      S_IDLE: begin
        if (q_valid) begin
          w_nxt  = q_word;
          ob_nxt = 8'd0;
          st_nxt = ST_OK;
          if (q_word.command == CMD_APPEND) begin
            if (len_r < LW'(PROGRAM_DEPTH)) begin
              pw_en   = 1'b1;
              len_nxt = len_r + 1'b1;
            end else begin
              st_nxt = ST_FULL;
            end
            state_nxt = S_OUT;
          end else if (halt_r) begin
            st_nxt    = ST_HALT;
            state_nxt = S_OUT;
          end else if (ip_r >= len_r) begin
            halt_nxt  = 1'b1;
            st_nxt    = (dep_r != '0) ? ST_UNCLOSED : ST_HALT;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      // memory reads in flight
      S_READ: state_nxt = S_EXEC;
      // carry out one instruction
      S_EXEC: begin
        state_nxt = S_OUT;
        ip_nxt    = ip_r + 1'b1;
        case (op_r)
          CH_PLUS:  begin tw_en = 1'b1; tw_data = cell_r + 8'd1; end
          CH_MINUS: begin tw_en = 1'b1; tw_data = cell_r - 8'd1; end
          CH_RIGHT: if (ptr_r != TAPE_LAST) ptr_nxt = ptr_r + 1'b1;
          CH_LEFT:  ptr_nxt = (ptr_r == '0) ? TAPE_LAST : ptr_r - 1'b1;
          CH_DOT:   begin st_nxt = ST_OUT; ob_nxt = cell_r; end
          CH_COMMA: begin tw_en = 1'b1; tw_data = w_r.data_byte; end
          CH_OPEN: begin
            if (cell_r == 8'd0) begin
              ip_nxt    = ip_r;
              scan_nxt  = ip_r + 1'b1;
              lvl_nxt   = '0;
              state_nxt = S_SCAN;
            end else if (dep_r >= DW'(STACK_DEPTH)) begin
              ip_nxt   = ip_r;
              halt_nxt = 1'b1;
              st_nxt   = ST_OVERFLOW;
            end else begin
              sw_en   = 1'b1;
              dep_nxt = dep_r + 1'b1;
            end
          end
          CH_CLOSE: begin
            if (dep_r == '0) begin
              ip_nxt   = ip_r;
              halt_nxt = 1'b1;
              st_nxt   = ST_STRAY;
            end else if (cell_r != 8'd0) begin
              ip_nxt = {1'b0, top_r} + 1'b1;
            end else begin
              dep_nxt = dep_r - 1'b1;
            end
          end
          default: ;
        endcase
      end
      // forward scan: issue read of the next program byte
      S_SCAN: begin
        pr_addr = scan_r[PW-1:0];
        if (scan_r >= len_r) begin
          halt_nxt  = 1'b1;
          st_nxt    = ST_UNCLOSED;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCANR;
        end
      end
      // forward scan: test the byte
      S_SCANR: begin
        state_nxt = S_SCAN;
        scan_nxt  = scan_r + 1'b1;
        if (op_r == CH_OPEN) begin
          lvl_nxt = lvl_r + 1'b1;
        end else if (op_r == CH_CLOSE) begin
          if (lvl_r == '0) begin
            ip_nxt    = scan_r + 1'b1;
            state_nxt = S_OUT;
          end else begin
            lvl_nxt = lvl_r - 1'b1;
          end
        end
      end
      // hold the result word
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      len_r <= '0; ptr_r <= '0; ip_r <= '0; dep_r <= '0;
      halt_r <= 1'b0; clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt; ptr_r <= ptr_nxt; ip_r <= ip_nxt; dep_r <= dep_nxt;
      halt_r <= halt_nxt; clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt; scan_r <= scan_nxt; lvl_r <= lvl_nxt;
    st_r <= st_nxt; ob_r <= ob_nxt;
  end

  // program store
  always_ff @(posedge clk) begin
    if (pw_en) prog_mem[len_r[PW-1:0]] <= q_word.data_byte;
    op_r <= prog_mem[pr_addr];
  end

  // tape
  always_ff @(posedge clk) begin
    if (tw_en) tape_mem[tw_addr] <= tw_data;
    cell_r <= tape_mem[ptr_r];
  end

  // bracket stack
  always_ff @(posedge clk) begin
    if (sw_en) stk_mem[dep_r[SW-1:0]] <= ip_r[PW-1:0];
    top_r <= stk_mem[SW'(dep_r - 1'b1)];
  end

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(PROGRAM_DEPTH)) else $error("program length overrun");
  a_dep: assert property (@(posedge clk) disable iff (!rst_n)
    dep_r <= DW'(STACK_DEPTH)) else $error("stack depth overrun");
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt flag dropped");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(st_r))
    else $error("result changed while stalled");

endmodule

// ===== rtl/core/tape_language_instruction_machine_top.sv =====
// tape language machine: load a program, then step it one instruction at a time
// input channel in_*: in_command 0 appends in_data_byte to the program store,
//   1 executes one instruction (in_data_byte is the byte for ',')
// result channel out_*: exactly one word per input word, in order, carrying
//   status, emitted byte and the program counter after the step
// a two-word queue in front decouples intake from the executing back end
// appends and halted steps go straight to a result; ordinary instructions
//   first read program and tape memory, then do the update
// the single back end state machine finishes one word before taking the next,
//   with registered memory reads; a '[' on a zero cell scans the program byte
//   by byte (read, then test) until its matching ']' or the program's end
// reset: synchronous active low; afterwards the tape is cleared one cell per
//   cycle over all TAPE_CELLS cells; meanwhile words queue but do not execute
// a stalled result simply holds; the back end waits and the queue fills
module tape_language_instruction_machine_top
  import tlim_pkg::*;
#(
  parameter int TAPE_CELLS    = 1024,
  parameter int PROGRAM_DEPTH = 1024,
  parameter int STACK_DEPTH   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_out_byte,
  output logic [10:0] out_program_counter
);

  logic       q_valid, q_ready;
  tlim_word_t q_word;

  tlim_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_data_byte,
    .q_valid, .q_ready, .q_word
  );

  tlim_back #(
    .TAPE_CELLS(TAPE_CELLS), .PROGRAM_DEPTH(PROGRAM_DEPTH), .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_word,
    .out_valid, .out_ready, .out_status, .out_out_byte, .out_program_counter
  );

endmodule
